// ===== rtl/core/biquad_iir_q16_saturating_unit_assert.svh =====
// assertion macros shared by the biquad checker
`ifndef BIQUAD_IIR_Q16_SATURATING_UNIT_ASSERT_SVH
`define BIQUAD_IIR_Q16_SATURATING_UNIT_ASSERT_SVH

// clocked assertion, quiet while reset is held
`define BQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, quiet while reset is held
`define BQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define BQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bq_pkg.sv =====
// types and constants for the q16.16 biquad unit
package bq_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_BITS = 16;
  localparam int SHIFT_W   = ACC_W - FRAC_BITS;
  localparam int NUM_COEFS = 5;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic KIND_FILTER = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] sample_in;
  } bq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered_value;
    logic                     overflow;
  } bq_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] b0;
    logic signed [DATA_W-1:0] b1;
    logic signed [DATA_W-1:0] b2;
    logic signed [DATA_W-1:0] a1;
    logic signed [DATA_W-1:0] a2;
  } bq_coef_t;

  typedef struct packed {
    logic step;
    logic clear;
  } bq_hist_ctrl_t;

endpackage

// ===== rtl/core/biquad_iir_q16_saturating_unit.sv =====
// items pass the input register, then the result register; a blocked result slot holds them
// throughput: one item per cycle while out_stall is low; the output feeds back through history
// clear items give no result; they never wait on the output side
// reset (rst_n low, synchronous): valids drop, coefficients and history go to zero
// pready is always high; a coefficient write also zeroes the history
module biquad_iir_q16_saturating_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // sample items in
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bq_pkg::bq_in_t             in_data,
  // result items out
  output logic                       out_valid,
  input  logic                       out_stall,
  output bq_pkg::bq_out_t            out_data,
  // apb coefficient port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bq_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [bq_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [bq_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                       cfg_pready
);
  import bq_pkg::*;

  // input register
  logic          s1_valid_r, s1_valid_nxt;
  bq_in_t        s1_data_r;
  // result register
  logic          out_valid_r, out_valid_nxt;
  bq_out_t       out_data_r;

  bq_coef_t      coefs;
  logic          cfg_clear;
  bq_hist_ctrl_t hist_ctrl;
  bq_out_t       result;

  logic          out_free;
  logic          s1_adv;
  logic          s1_is_clear;
  logic          fire;
  logic          in_take;

  bq_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .coefs      (coefs),
    .hist_clear (cfg_clear)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free    = !out_valid_r || !out_stall;
  assign s1_is_clear = (s1_data_r.kind == KIND_CLEAR);
  // a clear item never needs the result slot
  assign s1_adv      = s1_valid_r && (s1_is_clear || out_free);
  assign fire        = s1_adv && !s1_is_clear;

  // hold new items only while the staged one is blocked
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // history moves on a filtered item that fits without saturation, clears on a clear item or coefficient write
  assign hist_ctrl.step  = fire;
  assign hist_ctrl.clear = (s1_adv && s1_is_clear) || cfg_clear;

  bq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .coefs  (coefs),
    .sample (s1_data_r.sample_in),
    .ctrl   (hist_ctrl),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/bq_regs.sv =====
// apb coefficient register file
module bq_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bq_pkg::ADDR_W-1:0]   paddr,
  input  logic [bq_pkg::DATA_W-1:0]   pwdata,
  output logic [bq_pkg::DATA_W-1:0]   prdata,
  output logic                        pready,
  output bq_pkg::bq_coef_t            coefs,
  output logic                        hist_clear
);
  import bq_pkg::*;

  bq_coef_t         coef_r;
  bq_coef_t         coef_nxt;
  logic [IDX_W-1:0] idx;
  logic             wr_en;
  logic             hit;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    coef_nxt = coef_r;
    hit      = 1'b1;
    case (idx)
      REG_B0:  coef_nxt.b0 = pwdata;
      REG_B1:  coef_nxt.b1 = pwdata;
      REG_B2:  coef_nxt.b2 = pwdata;
      REG_A1:  coef_nxt.a1 = pwdata;
      REG_A2:  coef_nxt.a2 = pwdata;
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    case (idx)
      REG_B0:  prdata = coef_r.b0;
      REG_B1:  prdata = coef_r.b1;
      REG_B2:  prdata = coef_r.b2;
      REG_A1:  prdata = coef_r.a1;
      REG_A2:  prdata = coef_r.a2;
      default: prdata = '0;
    endcase
  end

  // any coefficient write restarts the filter history
  assign hist_clear = wr_en && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (hist_clear) begin
      coef_r <= coef_nxt;
    end
  end

  assign coefs = coef_r;

endmodule

// ===== rtl/core/bq_core.sv =====
// biquad datapath: five products, wide sum, shift, saturate, history
module bq_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bq_pkg::bq_coef_t                  coefs,
  input  logic signed [bq_pkg::DATA_W-1:0]  sample,
  input  bq_pkg::bq_hist_ctrl_t             ctrl,
  output bq_pkg::bq_out_t                   result
);
  import bq_pkg::*;

  logic signed [DATA_W-1:0]  x1_r, x2_r, y1_r, y2_r;
  logic signed [DATA_W-1:0]  x1_nxt, x2_nxt, y1_nxt, y2_nxt;
  logic signed [DATA_W-1:0]  c0, c1, c2, c3, c4;
  logic signed [PROD_W-1:0]  p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]   acc;
  logic        [SHIFT_W-1:0] shifted;
  logic        [SHIFT_W-DATA_W:0] top_bits;
  logic                      fits;

  assign c0 = coefs.b0;
  assign c1 = coefs.b1;
  assign c2 = coefs.b2;
  assign c3 = coefs.a1;
  assign c4 = coefs.a2;

  assign p0 = c0 * sample;
  assign p1 = c1 * x1_r;
  assign p2 = c2 * x2_r;
  assign p3 = c3 * y1_r;
  assign p4 = c4 * y2_r;

  // exact sum, wide enough that it never wraps
  assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4);

  // floor shift by the fraction width
  assign shifted  = acc[ACC_W-1:FRAC_BITS];
  assign top_bits = shifted[SHIFT_W-1:DATA_W-1];
  assign fits     = (&top_bits) || !(|top_bits);

  always_comb begin
    if (fits) begin
      result.filtered_value = shifted[DATA_W-1:0];
      result.overflow       = 1'b0;
    end else begin
      result.filtered_value = acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
      result.overflow       = 1'b1;
    end
  end

  always_comb begin
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    y1_nxt = y1_r;
    y2_nxt = y2_r;
    if (ctrl.clear) begin
      x1_nxt = '0;
      x2_nxt = '0;
      y1_nxt = '0;
      y2_nxt = '0;
    end else if (ctrl.step && fits) begin
      x2_nxt = x1_r;
      x1_nxt = sample;
      y2_nxt = y1_r;
      y1_nxt = shifted[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else begin
      x1_r <= x1_nxt;
      x2_r <= x2_nxt;
      y1_r <= y1_nxt;
      y2_r <= y2_nxt;
    end
  end

endmodule

// ===== rtl/core/bq_checker.sv =====
// port-level checks for the biquad unit, bound to the top level
`include "biquad_iir_q16_saturating_unit_assert.svh"

module bq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input bq_pkg::bq_in_t            in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input bq_pkg::bq_out_t           out_data,
  input logic                      cfg_pready
);
  import bq_pkg::*;

  logic in_held;
  logic out_held;
  logic out_railed;

  assign in_held    = in_valid && in_stall;
  assign out_held   = out_valid && out_stall;
  assign out_railed = (out_data.filtered_value == SAT_MAX) ||
                      (out_data.filtered_value == SAT_MIN);

  // a blocked result stays put
  `BQ_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled result moved")

  // a blocked input item stays put
  `BQ_ASSERT_NEXT(a_in_hold, in_held, in_valid && $stable(in_data), "stalled input item moved")

  // overflow only ever comes with a rail value
  `BQ_ASSERT_IMP(a_sat_value, out_valid && out_data.overflow, out_railed, "overflow without rail")

  // input side waits only when the result side is blocked
  `BQ_ASSERT_IMP(a_stall_cause, in_stall, out_held, "input stalled with free result slot")

  // register port never inserts wait states
  `BQ_ASSERT(a_pready, cfg_pready, "pready low")

endmodule

bind biquad_iir_q16_saturating_unit bq_checker u_bq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_data    (in_data),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
